FILE: hdl/aspc_pkg.sv
// shared types, constants and codes of the aspect stretch and crop decision block
`default_nettype none

package aspc_pkg;

   // field widths
   localparam int DIM_W   = 13;
   localparam int Q16_W   = 20;
   localparam int TOL_W   = 14;
   localparam int CAP_W   = 10;
   localparam int DIR_W   = 2;
   localparam int IDX_W   = 3;
   localparam int PIX_W   = 12;

   // fixed point and limit constants
   localparam logic [Q16_W-1:0] Q16_ONE         = 20'd65536;
   localparam logic [Q16_W-1:0] MIN_STRETCH_Q16 = 20'd65536;
   localparam logic [Q16_W-1:0] MAX_STRETCH_Q16 = 20'd262144;
   localparam logic [CAP_W-1:0] CROP_CAP        = 10'd1000;
   localparam int               HUNDREDTHS_FULL = 10000;

   // divider geometry: quotient saturates at all ones
   localparam int NUM_W      = 46;
   localparam int DEN_W      = 33;
   localparam int QUO_W      = 20;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_BITS;
   localparam int DIV_LAT    = DIV_STAGES + 1;

   // unit latencies
   localparam int MAP_LAT  = DIV_LAT + 3;
   localparam int CROP_LAT = DIV_LAT + 2;

   // status codes
   localparam logic [3:0] ST_CROPPED     = 4'd0;
   localparam logic [3:0] ST_BAD_STRETCH = 4'd1;
   localparam logic [3:0] ST_BAD_SOURCE  = 4'd2;
   localparam logic [3:0] ST_NO_TARGET   = 4'd3;
   localparam logic [3:0] ST_BELOW_MIN   = 4'd4;
   localparam logic [3:0] ST_CROP_OFF    = 4'd5;
   localparam logic [3:0] ST_NOT_APPLIC  = 4'd6;
   localparam logic [3:0] ST_WITHIN      = 4'd7;
   localparam logic [3:0] ST_NO_EXTENT   = 4'd8;
   localparam logic [3:0] ST_CANNOT      = 4'd9;
   localparam logic [3:0] ST_ROUNDS_ZERO = 4'd10;
   localparam logic [3:0] ST_EMPTY       = 4'd11;
   localparam logic [3:0] ST_UNSAFE      = 4'd12;

   // mapping modes
   localparam logic [1:0] MODE_WAIT   = 2'd0;
   localparam logic [1:0] MODE_PASS   = 2'd1;
   localparam logic [1:0] MODE_ACTIVE = 2'd2;
   localparam logic [1:0] MODE_SAFE   = 2'd3;

   // direction rules
   localparam logic [DIR_W-1:0] DIR_NARROWER = 2'd1;
   localparam logic [DIR_W-1:0] DIR_WIDER    = 2'd2;

   // register indexes
   localparam logic [IDX_W-1:0] REG_TARGET    = 3'd0;
   localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd1;
   localparam logic [IDX_W-1:0] REG_MINIMUM   = 3'd2;
   localparam logic [IDX_W-1:0] REG_DIRECTION = 3'd3;
   localparam logic [IDX_W-1:0] REG_STRETCH   = 3'd4;
   localparam logic [IDX_W-1:0] REG_MAX_CROP  = 3'd5;
   localparam logic [IDX_W-1:0] REG_PREF      = 3'd6;

   typedef struct packed {
      logic [Q16_W-1:0] target_aspect;
      logic [TOL_W-1:0] tolerance_hundredths;
      logic [Q16_W-1:0] minimum_aspect;
      logic [DIR_W-1:0] direction_rule;
      logic [Q16_W-1:0] max_stretch;
      logic [CAP_W-1:0] max_crop_hundredths;
      logic             crop_preference;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_aspect:        20'd116508,
      tolerance_hundredths: 14'd100,
      minimum_aspect:       20'd0,
      direction_rule:       2'd0,
      max_stretch:          20'd98304,
      max_crop_hundredths:  10'd0,
      crop_preference:      1'b0
   };

   // result of one mapping evaluation
   typedef struct packed {
      logic [1:0]       mode;
      logic [3:0]       why;
      logic             wider;
      logic [Q16_W-1:0] ratio;
   } map_res_type;

   // context that travels along the main pipeline
   typedef struct packed {
      logic             vld;
      logic [DIM_W-1:0] l;
      logic [DIM_W-1:0] t;
      logic [DIM_W-1:0] r;
      logic [DIM_W-1:0] b;
      logic [3:0]       status;
      logic [1:0]       omode;
      logic             wider;
      logic [Q16_W-1:0] ratio;
      logic [DIM_W-1:0] ext;
      logic [DIM_W-1:0] crop;
      logic [DIM_W-1:0] cl;
      logic [DIM_W-1:0] ct;
      logic [DIM_W-1:0] cr;
      logic [DIM_W-1:0] cb;
   } ctx_type;

   // one result beat
   typedef struct packed {
      logic [3:0]       status;
      logic [1:0]       omode;
      logic [1:0]       fmode;
      logic             vert;
      logic [Q16_W-1:0] ratio;
      logic             applied;
      logic             lr;
      logic [PIX_W-1:0] pix;
      logic [DIM_W-1:0] l;
      logic [DIM_W-1:0] t;
      logic [DIM_W-1:0] r;
      logic [DIM_W-1:0] b;
   } out_type;

endpackage

`default_nettype wire

FILE: hdl/aspc_div.sv
// pipelined restoring divider, saturating quotient, two bits per stage
`default_nettype none

module aspc_div
   import aspc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num_i,
   input  wire logic [DEN_W-1:0] den_i,
   output logic      [QUO_W-1:0] quo_o
);

   localparam int DW = DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [0:DIV_STAGES];
   logic [DEN_W-1:0] den_ff [0:DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [0:DIV_STAGES];
   logic             sat_ff [0:DIV_STAGES];

   logic [NUM_W-1:0] rem_in [0:DIV_STAGES];
   logic [QUO_W-1:0] quo_in [0:DIV_STAGES];
   logic             sat_in;

   // first stage: saturation check, then one pair of quotient bits per stage
   always_comb begin
      logic [DW-1:0]       r;
      logic [DW-1:0]       sh;
      logic [DIV_BITS-1:0] bits;
      sat_in    = DW'(num_i) >= (DW'(den_i) << QUO_W);
      rem_in[0] = num_i;
      quo_in[0] = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         r    = DW'(rem_ff[k-1]);
         bits = '0;
         for (int j = 0; j < DIV_BITS; j++) begin
            sh = DW'(den_ff[k-1]) << (QUO_W - 1 - (k - 1) * DIV_BITS - j);
            if (r >= sh) begin
               r = r - sh;
               bits[DIV_BITS-1-j] = 1'b1;
            end
         end
         rem_in[k] = r[NUM_W-1:0];
         quo_in[k] = {quo_ff[k-1][QUO_W-DIV_BITS-1:0], bits};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         den_ff[0] <= den_i;
         quo_ff[0] <= quo_in[0];
         sat_ff[0] <= sat_in;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in[k];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign quo_o = sat_ff[DIV_STAGES] ? {QUO_W{1'b1}} : quo_ff[DIV_STAGES];

endmodule

`default_nettype wire

FILE: hdl/aspc_map.sv
// mapping evaluation of one rectangle: products, tolerance test, ratio divide, mode
`default_nettype none

module aspc_map
   import aspc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire cfg_type          cfg,
   input  wire logic [DIM_W-1:0] w_i,
   input  wire logic [DIM_W-1:0] h_i,
   output map_res_type           res_o
);

   typedef struct packed {
      logic [3:0] why;
      logic       wider;
      logic       pass;
   } side_type;

   // stage one: target and minimum products
   logic [DEN_W-1:0] th_ff, mh_ff;
   logic [DIM_W-1:0] w1_ff, h1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         th_ff <= DEN_W'(cfg.target_aspect) * DEN_W'(h_i);
         mh_ff <= DEN_W'(cfg.minimum_aspect) * DEN_W'(h_i);
         w1_ff <= w_i;
         h1_ff <= h_i;
      end
   end

   // stage two: orientation, tolerance products, divider operands
   logic [DEN_W-1:0] sw, ad;
   logic             wider_in;
   logic [46:0]      ad10k_ff, lim_ff;
   logic             wider_ff, below_ff, sw_lt_th_ff, zero_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;

   always_comb begin
      sw       = {4'd0, w1_ff, 16'd0};
      wider_in = sw > th_ff;
      ad       = wider_in ? (sw - th_ff) : (th_ff - sw);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad10k_ff    <= 47'(ad) * 47'(HUNDREDTHS_FULL);
         lim_ff      <= 47'(th_ff) * 47'(cfg.tolerance_hundredths);
         wider_ff    <= wider_in;
         below_ff    <= (cfg.minimum_aspect != '0) && (sw < mh_ff);
         sw_lt_th_ff <= sw < th_ff;
         zero_ff     <= (w1_ff == '0) || (h1_ff == '0);
         num_ff      <= wider_in ? {1'b0, w1_ff, 32'd0} : NUM_W'(th_ff);
         den_ff      <= wider_in ? th_ff : DEN_W'(w1_ff);
      end
   end

   // ratio divide
   logic [QUO_W-1:0] quo;

   aspc_div u_div (
      .clock (clock),
      .en    (en),
      .num_i (num_ff),
      .den_i (den_ff),
      .quo_o (quo)
   );

   // early-out reason and passthrough decision ride beside the divider
   side_type side_in;
   side_type side_ff [0:DIV_LAT-1];

   always_comb begin
      side_in.wider = wider_ff;
      if (cfg.max_stretch < MIN_STRETCH_Q16 || cfg.max_stretch > MAX_STRETCH_Q16) begin
         side_in.why = ST_BAD_STRETCH;
      end else if (zero_ff) begin
         side_in.why = ST_BAD_SOURCE;
      end else if (cfg.target_aspect == '0) begin
         side_in.why = ST_NO_TARGET;
      end else if (below_ff) begin
         side_in.why = ST_BELOW_MIN;
      end else begin
         side_in.why = ST_CROPPED;
      end
      side_in.pass = (ad10k_ff <= lim_ff)
                  || (cfg.direction_rule == DIR_NARROWER && !sw_lt_th_ff)
                  || (cfg.direction_rule == DIR_WIDER && !wider_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // final stage: mode
   map_res_type res_in, res_ff;

   always_comb begin
      res_in.why = side_ff[DIV_LAT-1].why;
      if (side_ff[DIV_LAT-1].why != ST_CROPPED) begin
         res_in.mode  = MODE_WAIT;
         res_in.wider = 1'b0;
         res_in.ratio = '0;
      end else begin
         res_in.wider = side_ff[DIV_LAT-1].wider;
         res_in.ratio = quo;
         if (side_ff[DIV_LAT-1].pass) begin
            res_in.mode = MODE_PASS;
         end else if (quo > cfg.max_stretch) begin
            res_in.mode = MODE_SAFE;
         end else begin
            res_in.mode = MODE_ACTIVE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res_o = res_ff;

endmodule

`default_nettype wire

FILE: hdl/aspc_crop.sv
// crop limit, target crop and required crop, three divides in parallel
`default_nettype none

module aspc_crop
   import aspc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire cfg_type          cfg,
   input  wire logic [DIM_W-1:0] ext_i,
   input  wire logic [Q16_W-1:0] ratio_i,
   output logic      [DIM_W-1:0] maxpix_o,
   output logic      [DIM_W-1:0] tgtpix_o,
   output logic      [DIM_W-1:0] reqpix_o
);

   logic [CAP_W-1:0] cap;

   assign cap = (cfg.max_crop_hundredths > CROP_CAP) ? CROP_CAP : cfg.max_crop_hundredths;

   // stage one: numerator products
   logic [22:0]      pmax_ff;
   logic [DEN_W-1:0] ptgt_ff, preq_ff;
   logic [Q16_W:0]   dbl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pmax_ff <= 23'(cap) * 23'(ext_i);
         ptgt_ff <= DEN_W'(ext_i) * DEN_W'(ratio_i - Q16_ONE);
         preq_ff <= (ratio_i > cfg.max_stretch)
                  ? DEN_W'(ext_i) * DEN_W'(ratio_i - cfg.max_stretch) : '0;
         dbl_ff  <= {ratio_i, 1'b0};
      end
   end

   // stage two: rounding-up bias for the required crop
   logic [NUM_W-1:0] nmax_ff, ntgt_ff, nreq_ff;
   logic [DEN_W-1:0] dbl2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nmax_ff <= NUM_W'(pmax_ff);
         ntgt_ff <= NUM_W'(ptgt_ff);
         nreq_ff <= NUM_W'(preq_ff) + NUM_W'(dbl_ff) - NUM_W'(1);
         dbl2_ff <= DEN_W'(dbl_ff);
      end
   end

   logic [QUO_W-1:0] qmax, qtgt, qreq;

   aspc_div u_div_max (
      .clock (clock),
      .en    (en),
      .num_i (nmax_ff),
      .den_i (DEN_W'(HUNDREDTHS_FULL)),
      .quo_o (qmax)
   );

   aspc_div u_div_tgt (
      .clock (clock),
      .en    (en),
      .num_i (ntgt_ff),
      .den_i (dbl2_ff),
      .quo_o (qtgt)
   );

   aspc_div u_div_req (
      .clock (clock),
      .en    (en),
      .num_i (nreq_ff),
      .den_i (dbl2_ff),
      .quo_o (qreq)
   );

   assign maxpix_o = qmax[DIM_W-1:0];
   assign tgtpix_o = qtgt[DIM_W-1:0];
   assign reqpix_o = qreq[DIM_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/aspect_stretch_crop_decision_top.sv
// top level: register file, main pipeline, crop decision and output skid
//
// Use: the request channel carries one source rectangle per beat
// (req_valid / req_stall); the response channel returns one decision per
// beat (rsp_valid / rsp_stall) in request order. Seven control registers
// are written through csr_valid / csr_index / csr_data, always ready; write
// them only while no request is in flight.
// Path: a request beat passes two mapping evaluations, the crop divides
// and four stages of glue and output before its response leaves.
// Throughput: one rectangle per cycle while req_stall is low; every divide
// is a pipeline of two-bit restoring steps, so nothing iterates.
// Reset clears the registers to their defaults and empties the pipeline.
// When the receiver stalls, the output register holds its beat and one more
// beat moves into a skid register; only then does req_stall rise and the
// whole pipeline freeze until the skid drains.
`default_nettype none

module aspect_stretch_crop_decision_top
   import aspc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_source_valid,
   input  wire logic [DIM_W-1:0] req_src_left,
   input  wire logic [DIM_W-1:0] req_src_top,
   input  wire logic [DIM_W-1:0] req_src_right,
   input  wire logic [DIM_W-1:0] req_src_bottom,

   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [3:0]       rsp_status,
   output logic      [1:0]       rsp_original_mode,
   output logic      [1:0]       rsp_final_mode,
   output logic                  rsp_warp_vertical,
   output logic      [Q16_W-1:0] rsp_requested_ratio,
   output logic                  rsp_crop_applied,
   output logic                  rsp_crop_left_right,
   output logic      [PIX_W-1:0] rsp_crop_pixels,
   output logic      [DIM_W-1:0] rsp_out_left,
   output logic      [DIM_W-1:0] rsp_out_top,
   output logic      [DIM_W-1:0] rsp_out_right,
   output logic      [DIM_W-1:0] rsp_out_bottom,

   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [Q16_W-1:0] csr_data
);

   // control registers
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TARGET:    cfg_ff.target_aspect        <= csr_data;
            REG_TOLERANCE: cfg_ff.tolerance_hundredths <= csr_data[TOL_W-1:0];
            REG_MINIMUM:   cfg_ff.minimum_aspect       <= csr_data;
            REG_DIRECTION: cfg_ff.direction_rule       <= csr_data[DIR_W-1:0];
            REG_STRETCH:   cfg_ff.max_stretch          <= csr_data;
            REG_MAX_CROP:  cfg_ff.max_crop_hundredths  <= csr_data[CAP_W-1:0];
            REG_PREF:      cfg_ff.crop_preference      <= csr_data[0];
            default:       cfg_ff                      <= cfg_ff;
         endcase
      end
   end

   // pipeline advance: frozen only while the skid register is full
   logic skid_vld_ff, out_vld_ff;
   logic en;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // input stage: source and crop-enable checks
   ctx_type a_in, a_ff;

   always_comb begin
      a_in        = '0;
      a_in.vld    = req_valid;
      a_in.l      = req_src_left;
      a_in.t      = req_src_top;
      a_in.r      = req_src_right;
      a_in.b      = req_src_bottom;
      a_in.cl     = req_src_left;
      a_in.ct     = req_src_top;
      a_in.cr     = req_src_right;
      a_in.cb     = req_src_bottom;
      if (!req_source_valid || req_src_right <= req_src_left
          || req_src_bottom <= req_src_top) begin
         a_in.status = ST_BAD_SOURCE;
      end else if (cfg_ff.max_crop_hundredths == '0) begin
         a_in.status = ST_CROP_OFF;
      end else begin
         a_in.status = ST_CROPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
      end else if (en) begin
         a_ff <= a_in;
      end
   end

   // first mapping evaluation of the source rectangle
   map_res_type map1;
   ctx_type     d1_ff [0:MAP_LAT-1];

   aspc_map u_map_src (
      .clock (clock),
      .en    (en),
      .cfg   (cfg_ff),
      .w_i   (a_ff.r - a_ff.l),
      .h_i   (a_ff.b - a_ff.t),
      .res_o (map1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_LAT; i++) begin
            d1_ff[i].vld <= 1'b0;
         end
      end else if (en) begin
         d1_ff[0] <= a_ff;
         for (int i = 1; i < MAP_LAT; i++) begin
            d1_ff[i] <= d1_ff[i-1];
         end
      end
   end

   // mapping outcome and crop extent
   ctx_type p_in, p_ff;

   always_comb begin
      p_in     = d1_ff[MAP_LAT-1];
      p_in.ext = map1.wider ? (p_in.r - p_in.l) : (p_in.b - p_in.t);
      if (p_in.status == ST_CROPPED) begin
         p_in.omode = map1.mode;
         p_in.wider = map1.wider;
         p_in.ratio = map1.ratio;
         if (map1.mode == MODE_WAIT) begin
            p_in.status = map1.why;
         end else if (map1.mode == MODE_PASS) begin
            p_in.status = ST_NOT_APPLIC;
         end else if (!cfg_ff.crop_preference && map1.mode != MODE_SAFE) begin
            p_in.status = ST_WITHIN;
         end else if (p_in.ext <= DIM_W'(2)) begin
            p_in.status = ST_NO_EXTENT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff.vld <= 1'b0;
      end else if (en) begin
         p_ff <= p_in;
      end
   end

   // crop amounts
   logic [DIM_W-1:0] maxpix, tgtpix, reqpix;
   ctx_type          d2_ff [0:CROP_LAT-1];

   aspc_crop u_crop (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg_ff),
      .ext_i    (p_ff.ext),
      .ratio_i  (p_ff.ratio),
      .maxpix_o (maxpix),
      .tgtpix_o (tgtpix),
      .reqpix_o (reqpix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CROP_LAT; i++) begin
            d2_ff[i].vld <= 1'b0;
         end
      end else if (en) begin
         d2_ff[0] <= p_ff;
         for (int i = 1; i < CROP_LAT; i++) begin
            d2_ff[i] <= d2_ff[i-1];
         end
      end
   end

   // crop choice and cropped rectangle
   ctx_type q_in, q_ff;

   always_comb begin
      q_in = d2_ff[CROP_LAT-1];
      if (!cfg_ff.crop_preference) begin
         q_in.crop = reqpix;
      end else begin
         q_in.crop = (maxpix < tgtpix) ? maxpix : tgtpix;
      end
      if (q_in.status == ST_CROPPED) begin
         if (!cfg_ff.crop_preference) begin
            if (reqpix == '0 || reqpix > maxpix || reqpix > tgtpix) begin
               q_in.status = ST_CANNOT;
            end
         end else if (q_in.crop == '0) begin
            q_in.status = ST_ROUNDS_ZERO;
         end
      end
      if (q_in.status == ST_CROPPED && {1'b0, q_in.ext} <= {q_in.crop, 1'b0}) begin
         q_in.status = ST_EMPTY;
      end
      if (q_in.wider) begin
         q_in.cl = q_in.l + q_in.crop;
         q_in.cr = q_in.r - q_in.crop;
      end else begin
         q_in.ct = q_in.t + q_in.crop;
         q_in.cb = q_in.b - q_in.crop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.vld <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   // second mapping evaluation of the cropped rectangle
   map_res_type map2;
   ctx_type     d3_ff [0:MAP_LAT-1];

   aspc_map u_map_crop (
      .clock (clock),
      .en    (en),
      .cfg   (cfg_ff),
      .w_i   (q_ff.cr - q_ff.cl),
      .h_i   (q_ff.cb - q_ff.ct),
      .res_o (map2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_LAT; i++) begin
            d3_ff[i].vld <= 1'b0;
         end
      end else if (en) begin
         d3_ff[0] <= q_ff;
         for (int i = 1; i < MAP_LAT; i++) begin
            d3_ff[i] <= d3_ff[i-1];
         end
      end
   end

   // final decision beat
   ctx_type f;
   out_type f_out;
   logic    pipe_vld;

   always_comb begin
      f             = d3_ff[MAP_LAT-1];
      pipe_vld      = f.vld;
      f_out.status  = f.status;
      f_out.omode   = f.omode;
      f_out.fmode   = f.omode;
      f_out.vert    = f.wider;
      f_out.ratio   = f.ratio;
      f_out.applied = 1'b0;
      f_out.lr      = 1'b0;
      f_out.pix     = '0;
      f_out.l       = f.l;
      f_out.t       = f.t;
      f_out.r       = f.r;
      f_out.b       = f.b;
      if (f.status == ST_CROPPED) begin
         if (map2.mode != MODE_ACTIVE && map2.mode != MODE_PASS) begin
            f_out.status = ST_UNSAFE;
         end else begin
            f_out.fmode   = map2.mode;
            f_out.applied = 1'b1;
            f_out.lr      = f.wider;
            f_out.pix     = f.crop[PIX_W-1:0];
            f_out.l       = f.cl;
            f_out.t       = f.ct;
            f_out.r       = f.cr;
            f_out.b       = f.cb;
         end
      end
   end

   // output register with skid beat
   out_type out_ff, skid_ff;
   logic    out_ready;

   assign out_ready = !out_vld_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_ready) begin
         if (skid_vld_ff) begin
            out_ff      <= skid_ff;
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_ff     <= f_out;
            out_vld_ff <= pipe_vld;
         end
      end else if (en && pipe_vld) begin
         skid_ff     <= f_out;
         skid_vld_ff <= 1'b1;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_original_mode   = out_ff.omode;
   assign rsp_final_mode      = out_ff.fmode;
   assign rsp_warp_vertical   = out_ff.vert;
   assign rsp_requested_ratio = out_ff.ratio;
   assign rsp_crop_applied    = out_ff.applied;
   assign rsp_crop_left_right = out_ff.lr;
   assign rsp_crop_pixels     = out_ff.pix;
   assign rsp_out_left        = out_ff.l;
   assign rsp_out_top         = out_ff.t;
   assign rsp_out_right       = out_ff.r;
   assign rsp_out_bottom      = out_ff.b;

`ifndef SYNTHESIS
   // a skid beat exists only behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid beat without output beat");

   // a cropped result ends in a safe mapping
   a_crop_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CROPPED |->
         rsp_crop_applied && (rsp_final_mode == MODE_ACTIVE || rsp_final_mode == MODE_PASS))
      else $error("cropped result without safe final mapping");

   // any other status leaves the mapping and the crop fields untouched
   a_no_crop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_CROPPED |->
         !rsp_crop_applied && rsp_crop_pixels == '0 && rsp_final_mode == rsp_original_mode)
      else $error("uncropped result carries crop state");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench for the aspect stretch and crop decision block: directed and random rectangles against a local predictor
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import aspc_pkg::*;

   localparam int  RUN_LIMIT = 400000;
   localparam int  PHASES    = 10;
   localparam int  PER_PHASE = 180;
   localparam longint ONE_Q  = 65536;

   typedef struct {
      logic             vld;
      logic [DIM_W-1:0] l, t, r, b;
   } rect_type;

   logic clock, reset;
   logic req_valid, req_stall, req_source_valid;
   logic [DIM_W-1:0] req_src_left, req_src_top, req_src_right, req_src_bottom;
   logic rsp_valid, rsp_stall;
   logic [3:0] rsp_status;
   logic [1:0] rsp_original_mode, rsp_final_mode;
   logic rsp_warp_vertical, rsp_crop_applied, rsp_crop_left_right;
   logic [Q16_W-1:0] rsp_requested_ratio;
   logic [PIX_W-1:0] rsp_crop_pixels;
   logic [DIM_W-1:0] rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom;
   logic csr_valid, csr_ready;
   logic [IDX_W-1:0] csr_index;
   logic [Q16_W-1:0] csr_data;

   cfg_type  regs_shadow;
   rect_type rect_queue[$];
   out_type  pending_decisions[$];
   int       fail_count, beats_in, beats_out, cycle_count, gap_left, stall_left;
   int       crops_seen;
   bit       quiet;

   aspect_stretch_crop_decision_top dut (.*);

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // mapping of one rectangle extent under the shadow registers
   function automatic map_res_type map_extent(cfg_type c, longint w, longint h);
      map_res_type m;
      longint sw, th, q, d, ad, lim;
      m = '0;
      if (c.max_stretch < MIN_STRETCH_Q16 || c.max_stretch > MAX_STRETCH_Q16) begin
         m.why = ST_BAD_STRETCH;
         return m;
      end
      if (w == 0 || h == 0) begin
         m.why = ST_BAD_SOURCE;
         return m;
      end
      if (c.target_aspect == 0) begin
         m.why = ST_NO_TARGET;
         return m;
      end
      sw = w << 16;
      th = longint'(c.target_aspect) * h;
      if (c.minimum_aspect != 0 && sw < longint'(c.minimum_aspect) * h) begin
         m.why = ST_BELOW_MIN;
         return m;
      end
      m.wider = sw > th;
      q = m.wider ? (w << 32) / th : th / w;
      if (q > 1048575) q = 1048575;
      m.ratio = q[Q16_W-1:0];
      d = th - sw;
      ad = d < 0 ? -d : d;
      lim = longint'(c.tolerance_hundredths) * th;
      if (ad * 10000 <= lim) m.mode = MODE_PASS;
      else if (c.direction_rule == DIR_NARROWER && d * 10000 <= lim) m.mode = MODE_PASS;
      else if (c.direction_rule == DIR_WIDER && d * 10000 >= -lim) m.mode = MODE_PASS;
      else m.mode = (q > longint'(c.max_stretch)) ? MODE_SAFE : MODE_ACTIVE;
      return m;
   endfunction

   // full decision for one request beat
   function automatic out_type predict_decision(cfg_type c, rect_type s);
      out_type o;
      map_res_type m, cm;
      longint cap, ext, rq, maxpix, tgtpix, crop, num, den;
      longint l, t, r, b, cl, ct, cr, cb;
      l = longint'(s.l); t = longint'(s.t); r = longint'(s.r); b = longint'(s.b);
      o = '0;
      o.l = s.l; o.t = s.t; o.r = s.r; o.b = s.b;
      cap = c.max_crop_hundredths > CROP_CAP ? longint'(CROP_CAP)
                                             : longint'(c.max_crop_hundredths);
      crop = 0;
      if (!s.vld || r <= l || b <= t || r > 8192 || b > 8192) begin
         o.status = ST_BAD_SOURCE;
      end else if (cap == 0) begin
         o.status = ST_CROP_OFF;
      end else begin
         m = map_extent(c, r - l, b - t);
         o.omode = m.mode; o.fmode = m.mode; o.vert = m.wider; o.ratio = m.ratio;
         if (m.mode == MODE_WAIT) o.status = m.why;
         else if (m.mode == MODE_PASS) o.status = ST_NOT_APPLIC;
         else if (!c.crop_preference && m.mode != MODE_SAFE) o.status = ST_WITHIN;
         else begin
            ext = m.wider ? r - l : b - t;
            rq = longint'(m.ratio);
            maxpix = cap * ext / 10000;
            tgtpix = ext * (rq - ONE_Q) / (2 * rq);
            if (ext <= 2) o.status = ST_NO_EXTENT;
            else begin
               o.status = ST_CROPPED;
               if (!c.crop_preference) begin
                  num = rq > longint'(c.max_stretch)
                      ? ext * (rq - longint'(c.max_stretch)) : 0;
                  den = 2 * rq;
                  crop = (num + den - 1) / den;
                  if (crop == 0 || crop > maxpix || crop > tgtpix) o.status = ST_CANNOT;
               end else begin
                  crop = maxpix < tgtpix ? maxpix : tgtpix;
                  if (crop == 0) o.status = ST_ROUNDS_ZERO;
               end
               if (o.status == ST_CROPPED && ext <= 2 * crop) o.status = ST_EMPTY;
               if (o.status == ST_CROPPED) begin
                  cl = l; ct = t; cr = r; cb = b;
                  if (m.wider) begin
                     cl += crop; cr -= crop;
                  end else begin
                     ct += crop; cb -= crop;
                  end
                  cm = map_extent(c, cr - cl, cb - ct);
                  if (cm.mode != MODE_ACTIVE && cm.mode != MODE_PASS) o.status = ST_UNSAFE;
                  else begin
                     o.fmode = cm.mode; o.applied = 1'b1; o.lr = m.wider;
                     o.pix = crop[PIX_W-1:0];
                     o.l = cl[DIM_W-1:0]; o.t = ct[DIM_W-1:0];
                     o.r = cr[DIM_W-1:0]; o.b = cb[DIM_W-1:0];
                  end
               end
            end
         end
      end
      return o;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      fail_count++;
   endtask

   // request driver, random gaps between beats
   always @(posedge clock) begin
      rect_type it;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rect_queue.size() > 0) begin
            it = rect_queue.pop_front();
            req_valid        <= 1'b1;
            req_source_valid <= it.vld;
            req_src_left     <= it.l;
            req_src_top      <= it.t;
            req_src_right    <= it.r;
            req_src_bottom   <= it.b;
            if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on request beats, check on response beats
   always @(posedge clock) begin
      rect_type s;
      out_type want;
      if (!reset) begin
         cycle_count++;
         if (req_valid && !req_stall) begin
            s.vld = req_source_valid;
            s.l = req_src_left; s.t = req_src_top;
            s.r = req_src_right; s.b = req_src_bottom;
            pending_decisions.push_back(predict_decision(regs_shadow, s));
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (pending_decisions.size() == 0) begin
               report("unexpected response beat", 1, 0);
            end else begin
               want = pending_decisions.pop_front();
               if (want.applied) crops_seen++;
               if (rsp_status !== want.status)
                  report("status", int'(rsp_status), int'(want.status));
               if (rsp_original_mode !== want.omode)
                  report("original_mode", int'(rsp_original_mode), int'(want.omode));
               if (rsp_final_mode !== want.fmode)
                  report("final_mode", int'(rsp_final_mode), int'(want.fmode));
               if (rsp_warp_vertical !== want.vert)
                  report("warp_vertical", int'(rsp_warp_vertical), int'(want.vert));
               if (rsp_requested_ratio !== want.ratio)
                  report("requested_ratio", int'(rsp_requested_ratio), int'(want.ratio));
               if (rsp_crop_applied !== want.applied)
                  report("crop_applied", int'(rsp_crop_applied), int'(want.applied));
               if (rsp_crop_left_right !== want.lr)
                  report("crop_left_right", int'(rsp_crop_left_right), int'(want.lr));
               if (rsp_crop_pixels !== want.pix)
                  report("crop_pixels", int'(rsp_crop_pixels), int'(want.pix));
               if (rsp_out_left !== want.l)
                  report("out_left", int'(rsp_out_left), int'(want.l));
               if (rsp_out_top !== want.t)
                  report("out_top", int'(rsp_out_top), int'(want.t));
               if (rsp_out_right !== want.r)
                  report("out_right", int'(rsp_out_right), int'(want.r));
               if (rsp_out_bottom !== want.b)
                  report("out_bottom", int'(rsp_out_bottom), int'(want.b));
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // one register write, shadow updated on the write beat
   task automatic write_reg(logic [IDX_W-1:0] idx, logic [Q16_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_TARGET:    regs_shadow.target_aspect        = value;
         REG_TOLERANCE: regs_shadow.tolerance_hundredths = value[TOL_W-1:0];
         REG_MINIMUM:   regs_shadow.minimum_aspect       = value;
         REG_DIRECTION: regs_shadow.direction_rule       = value[DIR_W-1:0];
         REG_STRETCH:   regs_shadow.max_stretch          = value;
         REG_MAX_CROP:  regs_shadow.max_crop_hundredths  = value[CAP_W-1:0];
         REG_PREF:      regs_shadow.crop_preference      = value[0];
         default: ;
      endcase
   endtask

   task automatic write_all(cfg_type c);
      write_reg(REG_TARGET, c.target_aspect);
      write_reg(REG_TOLERANCE, Q16_W'(c.tolerance_hundredths));
      write_reg(REG_MINIMUM, c.minimum_aspect);
      write_reg(REG_DIRECTION, Q16_W'(c.direction_rule));
      write_reg(REG_STRETCH, c.max_stretch);
      write_reg(REG_MAX_CROP, Q16_W'(c.max_crop_hundredths));
      write_reg(REG_PREF, Q16_W'(c.crop_preference));
   endtask

   // wait for the pipeline to drain, then let it settle
   task automatic drain();
      do @(negedge clock);
      while (rect_queue.size() != 0 || req_valid || pending_decisions.size() != 0);
      repeat (60) @(negedge clock);
   endtask

   task automatic add_rect(bit v, int l, int t, int r, int b);
      rect_type it;
      it.vld = v; it.l = DIM_W'(l); it.t = DIM_W'(t); it.r = DIM_W'(r); it.b = DIM_W'(b);
      rect_queue.push_back(it);
   endtask

   // mostly rectangles near the target aspect so the crop path is reached
   task automatic add_random_rect();
      int l, t, w, h, k;
      longint ta;
      l = $urandom_range(0, 600);
      t = $urandom_range(0, 600);
      if ($urandom_range(0, 9) < 2 || regs_shadow.target_aspect == 0) begin
         add_rect($urandom_range(0, 30) != 0, $urandom_range(0, 8191), $urandom_range(0, 8191),
                  $urandom_range(0, 8191), $urandom_range(0, 8191));
      end else begin
         ta = longint'(regs_shadow.target_aspect);
         w = $urandom_range(3, 8191 - l);
         if ($urandom_range(0, 3) == 0) w = $urandom_range(3, 64);
         k = $urandom_range(4, 48);
         h = int'((longint'(w) * ONE_Q * k) / (ta * 16));
         if (h < 1) h = 1;
         if (h > 8191 - t) h = 8191 - t;
         add_rect(1'b1, l, t, l + w, t + h);
      end
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.target_aspect = $urandom_range(0, 15) == 0 ? 20'($urandom_range(0, 1048575))
                                                   : 20'($urandom_range(32768, 262144));
      c.tolerance_hundredths = $urandom_range(0, 7) == 0 ? 14'($urandom_range(0, 16383))
                                                         : 14'($urandom_range(0, 300));
      c.minimum_aspect = $urandom_range(0, 3) == 0 ? 20'($urandom_range(0, 131072)) : 20'd0;
      c.direction_rule = DIR_W'($urandom_range(0, 3));
      c.max_stretch = $urandom_range(0, 7) == 0 ? 20'($urandom_range(0, 1048575))
                                                : 20'($urandom_range(65536, 262144));
      c.max_crop_hundredths = $urandom_range(0, 15) == 0 ? 10'd0
                                                         : 10'($urandom_range(1, 1023));
      c.crop_preference = 1'($urandom_range(0, 1));
      return c;
   endfunction

   initial begin
      cfg_type c;
      fail_count = 0; beats_in = 0; beats_out = 0; cycle_count = 0; crops_seen = 0;
      quiet = 1'b0;
      regs_shadow = CFG_RESET;
      reset = 1'b1;
      req_valid = 1'b0; req_source_valid = 1'b0;
      req_src_left = '0; req_src_top = '0; req_src_right = '0; req_src_bottom = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: crop disabled everywhere
      add_rect(1'b1, 0, 0, 1920, 1080);
      add_rect(1'b1, 0, 0, 8191, 8191);
      drain();

      // directed corners under a 16:9 target with full crop range
      c = CFG_RESET;
      c.max_crop_hundredths = 10'd1000;
      write_all(c);
      add_rect(1'b0, 0, 0, 100, 100);
      add_rect(1'b1, 100, 0, 100, 50);
      add_rect(1'b1, 0, 50, 100, 50);
      add_rect(1'b1, 200, 0, 100, 50);
      add_rect(1'b1, 0, 0, 8191, 8191);
      add_rect(1'b1, 0, 0, 1920, 1080);
      add_rect(1'b1, 0, 0, 640, 480);
      add_rect(1'b1, 0, 0, 1000, 1000);
      add_rect(1'b1, 0, 0, 2, 1);
      add_rect(1'b1, 0, 0, 8191, 1);
      add_rect(1'b1, 0, 0, 1, 8191);
      add_rect(1'b1, 8190, 8190, 8191, 8191);
      add_rect(1'b1, 0, 0, 2500, 1000);
      drain();

      for (int p = 2; p < PHASES; p++) begin
         case (p)
            2: begin
               c = CFG_RESET;
               c.target_aspect = 20'd1048575; c.tolerance_hundredths = 14'd16383;
               c.direction_rule = DIR_NARROWER; c.max_stretch = MAX_STRETCH_Q16;
               c.max_crop_hundredths = 10'd1023; c.crop_preference = 1'b1;
               c.minimum_aspect = 20'd1048575;
            end
            3: begin
               c = CFG_RESET;
               c.target_aspect = 20'd0; c.max_crop_hundredths = 10'd1;
            end
            4: begin
               c = CFG_RESET;
               c.max_stretch = 20'd65535; c.max_crop_hundredths = 10'd500;
            end
            5: begin
               c = CFG_RESET;
               c.tolerance_hundredths = 14'd0; c.direction_rule = DIR_WIDER;
               c.max_stretch = MIN_STRETCH_Q16; c.max_crop_hundredths = 10'd1000;
               c.crop_preference = 1'b1; c.minimum_aspect = 20'd65536;
            end
            default: c = random_cfg();
         endcase
         write_all(c);
         if (p == PHASES - 1) quiet = 1'b1;
         for (int i = 0; i < (p < 4 ? PER_PHASE / 3 : PER_PHASE); i++) add_random_rect();
         // a second random setting inside the random-setting phases
         if (p >= 6) begin
            drain();
            write_all(random_cfg());
            for (int i = 0; i < PER_PHASE; i++) add_random_rect();
         end
         drain();
      end

      $display("%0d request beats and %0d response beats checked, %0d with a crop applied",
               beats_in, beats_out, crops_seen);
      $display("covered reset settings, register extremes and random settings over %0d phases",
               PHASES);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: aspect_stretch_crop_decision_top.f
hdl/aspc_pkg.sv
hdl/aspc_div.sv
hdl/aspc_map.sv
hdl/aspc_crop.sv
hdl/aspect_stretch_crop_decision_top.sv
tb/sv/testbench.sv
